[sv/bbr_pkg.sv]
// ---------------------------------------------------------------------------
// bbr_pkg: shared constants for the reflect-border box blur
// Register indexes, field widths and default sizing limits.
// ---------------------------------------------------------------------------
package bbr_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 7;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_W_BITS   = 11;
    localparam int CFG_H_BITS   = 13;
    localparam int CFG_R_BITS   = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 13;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int PIX_BITS = 8;
    // quotient bits of the rounding divider, one per cell
    localparam int QUO_BITS = 8;

endpackage

[sv/bbr_div_cell.sv]
// ---------------------------------------------------------------------------
// bbr_div_cell: one stage of the restoring divider chain
// Resolves one quotient bit and hands remainder, quotient and divisor on.
// ---------------------------------------------------------------------------
module bbr_div_cell #(
    parameter int REM_W = 19,
    parameter int DVS_W = 10,
    parameter int SHIFT = 7
) (
    input  logic                          i_clk,
    input  logic [REM_W-1:0]              i_rem,
    input  logic [bbr_pkg::QUO_BITS-1:0]  i_quo,
    input  logic [DVS_W-1:0]              i_dvs,
    output logic [REM_W-1:0]              o_rem,
    output logic [bbr_pkg::QUO_BITS-1:0]  o_quo,
    output logic [DVS_W-1:0]              o_dvs
);
    localparam int EXT_W = REM_W + DVS_W + SHIFT + 1;

    logic [EXT_W-1:0]             w_rem;
    logic [EXT_W-1:0]             w_sub;
    logic                         w_fit;
    logic [REM_W-1:0]             n_rem;
    logic [bbr_pkg::QUO_BITS-1:0] n_quo;

    logic [REM_W-1:0]             r_rem;
    logic [bbr_pkg::QUO_BITS-1:0] r_quo;
    logic [DVS_W-1:0]             r_dvs;

    assign w_rem = EXT_W'(i_rem);
    assign w_sub = EXT_W'(i_dvs) << SHIFT;
    assign w_fit = (w_rem >= w_sub);

    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        if (w_fit) begin
            n_rem        = REM_W'(w_rem - w_sub);
            n_quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= i_dvs;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

endmodule

[sv/box_blur_reflect_border.sv]
// ---------------------------------------------------------------------------
// box_blur_reflect_border: streaming box mean with reflect-101 borders
// Pixels in raster order go to a circular line store; each output sums its
// window from the store and is rounded through a chain of divider cells.
// ---------------------------------------------------------------------------
//  channel | signals                                        | dir
//  input   | i_in_valid / o_in_ready, i_op, i_pixel_in      | in
//  output  | o_out_valid / i_out_ready, o_pixel_out,        | out
//          | o_frame_last                                   |
//  config  | i_cfg_we, i_cfg_index, i_cfg_data              | in
//
// An item that gives a result passes through the transfer, one line store
// read per window pixel and a drain of the read, the divider chain, one
// cell per quotient bit, and the load of the output register.
// The next item is taken while the finished result waits in the output
// register; a stalled output holds back the next result, and input with it.
// Synchronous active-low reset; the line store has no clearing pass.
// Input is held off in the cycle after a register write.
// ---------------------------------------------------------------------------
module box_blur_reflect_border #(
    parameter int MAX_WIDTH  = bbr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = bbr_pkg::DEF_MAX_RADIUS,
    parameter int MAX_HEIGHT = bbr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [bbr_pkg::PIX_BITS-1:0]      i_pixel_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bbr_pkg::PIX_BITS-1:0]      o_pixel_out,
    output logic                              o_frame_last,
    input  logic                              i_cfg_we,
    input  logic [bbr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bbr_pkg::CFG_DAT_BITS-1:0]  i_cfg_data
);
    localparam int SLOTS   = 2 * MAX_RADIUS + 2;
    localparam int DEPTH   = SLOTS * MAX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = $clog2(SLOTS);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int RW      = $clog2(MAX_RADIUS + 1);
    localparam int OW      = $clog2(2 * MAX_RADIUS + 1);
    localparam int CW      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int AREA_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int KW      = $clog2(AREA_MAX + 1);
    localparam int SUMW    = $clog2(AREA_MAX * 255 + 1);
    localparam int REMW    = SUMW + 2;
    localparam int DVSW    = KW + 1;
    localparam int XS      = XW + 3;
    localparam int YS      = YW + 3;
    localparam int SS      = SW + 3;
    localparam int QB      = bbr_pkg::QUO_BITS;
    localparam int DCW     = $clog2(QB);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // raw registers
    logic [bbr_pkg::CFG_W_BITS-1:0] r_cfg_w;
    logic [bbr_pkg::CFG_H_BITS-1:0] r_cfg_h;
    logic [bbr_pkg::CFG_R_BITS-1:0] r_cfg_r;
    logic                           r_cfg_hold;

    // settled geometry
    logic [WW-1:0]   n_eff_w, r_eff_w;
    logic [HW-1:0]   n_eff_h, r_eff_h;
    logic [RW-1:0]   n_eff_r, r_eff_r;
    logic [CW-1:0]   r_total, r_delay;
    logic [KW-1:0]   r_area;

    logic [1:0]      r_state;
    logic [CW-1:0]   r_in_count, r_out_count;
    logic [XW-1:0]   r_wcol, r_ox, r_cx;
    logic [SW-1:0]   r_wslot, r_oslot, r_cslot;
    logic [YW-1:0]   r_oy, r_cy;
    logic            r_last_pend;

    logic [OW-1:0]   r_dxo, r_dyo;
    logic            r_issue_done, r_rd_vld;
    logic [bbr_pkg::PIX_BITS-1:0] r_mem_q;
    logic [SUMW-1:0] r_sum;
    logic [DCW:0]    r_div_cnt;

    logic            r_out_valid, r_frame_last;
    logic [bbr_pkg::PIX_BITS-1:0] r_pixel_out;

    logic [bbr_pkg::PIX_BITS-1:0] r_mem [DEPTH];

    logic            w_take, w_full, w_pix_ok, w_emit, w_frame_end, w_cfg_hit;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic signed [XS-1:0] w_xx, w_col;
    logic signed [YS-1:0] w_yy, w_row;
    logic signed [SS-1:0] w_slot;
    logic [SW-1:0]   w_rslot;
    logic [XW-1:0]   w_rcol;

    // settle register values into legal geometry
    always_comb begin
        int w, h, r;
        w = 32'(r_cfg_w);
        h = 32'(r_cfg_h);
        r = 32'(r_cfg_r);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        if (r > w - 1) r = w - 1;
        if (r > h - 1) r = h - 1;
        n_eff_w = WW'(w);
        n_eff_h = HW'(h);
        n_eff_r = RW'(r);
    end

    always_ff @(posedge i_clk) begin
        r_eff_w <= n_eff_w;
        r_eff_h <= n_eff_h;
        r_eff_r <= n_eff_r;
        r_total <= CW'(n_eff_w * n_eff_h);
        r_delay <= CW'(n_eff_r * n_eff_w + n_eff_r);
        r_area  <= KW'((2 * n_eff_r + 1) * (2 * n_eff_r + 1));
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_cfg_hold;
    assign w_take      = i_in_valid && o_in_ready;
    assign w_full      = (r_in_count >= r_total);
    assign w_pix_ok    = (i_op == bbr_pkg::OP_PIXEL) && !w_full;
    assign w_emit      = (i_op == bbr_pkg::OP_PIXEL)
                       ? (w_pix_ok && (r_in_count >= r_delay))
                       : (w_full && (r_out_count < r_total));
    assign w_frame_end = ((r_out_count + CW'(1)) >= r_total);
    assign w_cfg_hit   = i_cfg_we && (i_cfg_index inside {bbr_pkg::REG_IMAGE_WIDTH,
                                                          bbr_pkg::REG_IMAGE_HEIGHT,
                                                          bbr_pkg::REG_WINDOW_RADIUS});
    assign w_waddr     = AW'(r_wslot * MAX_WIDTH) + AW'(r_wcol);

    // window coordinate with reflect-101 mirroring
    always_comb begin
        w_xx = $signed(XS'(r_cx)) + $signed(XS'(r_dxo)) - $signed(XS'(r_eff_r));
        if (w_xx < 0) begin
            w_col = -w_xx;
        end else if (w_xx >= $signed(XS'(r_eff_w))) begin
            w_col = $signed(XS'(2 * (r_eff_w - WW'(1)))) - w_xx;
        end else begin
            w_col = w_xx;
        end
        w_yy = $signed(YS'(r_cy)) + $signed(YS'(r_dyo)) - $signed(YS'(r_eff_r));
        if (w_yy < 0) begin
            w_row = -w_yy;
        end else if (w_yy >= $signed(YS'(r_eff_h))) begin
            w_row = $signed(YS'(2 * (r_eff_h - HW'(1)))) - w_yy;
        end else begin
            w_row = w_yy;
        end
        // mirrored row stays within radius of the center row
        w_slot = $signed(SS'(r_cslot)) + SS'(w_row - $signed(YS'(r_cy)));
        if (w_slot < 0) begin
            w_slot = w_slot + SS'(SLOTS);
        end else if (w_slot >= SS'(SLOTS)) begin
            w_slot = w_slot - SS'(SLOTS);
        end
    end

    assign w_rslot = SW'(w_slot);
    assign w_rcol  = XW'(w_col);
    assign w_raddr = AW'(w_rslot * MAX_WIDTH) + AW'(w_rcol);

    // line store
    always_ff @(posedge i_clk) begin
        if (w_take && w_pix_ok) begin
            r_mem[w_waddr] <= i_pixel_in;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= bbr_pkg::CFG_W_BITS'(640);
            r_cfg_h    <= bbr_pkg::CFG_H_BITS'(480);
            r_cfg_r    <= bbr_pkg::CFG_R_BITS'(1);
            r_cfg_hold <= 1'b1;
        end else begin
            r_cfg_hold <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bbr_pkg::REG_IMAGE_WIDTH:
                        r_cfg_w <= i_cfg_data[bbr_pkg::CFG_W_BITS-1:0];
                    bbr_pkg::REG_IMAGE_HEIGHT:
                        r_cfg_h <= i_cfg_data[bbr_pkg::CFG_H_BITS-1:0];
                    bbr_pkg::REG_WINDOW_RADIUS:
                        r_cfg_r <= i_cfg_data[bbr_pkg::CFG_R_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // divider chain
    logic [REMW-1:0] w_c_rem [QB+1];
    logic [QB-1:0]   w_c_quo [QB+1];
    logic [DVSW-1:0] w_c_dvs [QB+1];

    assign w_c_rem[0] = REMW'({r_sum, 1'b0}) + REMW'(r_area);
    assign w_c_quo[0] = '0;
    assign w_c_dvs[0] = DVSW'({r_area, 1'b0});

    for (genvar g = 0; g < QB; g++) begin : g_cell
        bbr_div_cell #(
            .REM_W (REMW),
            .DVS_W (DVSW),
            .SHIFT (QB - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_rem (w_c_rem[g]),
            .i_quo (w_c_quo[g]),
            .i_dvs (w_c_dvs[g]),
            .o_rem (w_c_rem[g+1]),
            .o_quo (w_c_quo[g+1]),
            .o_dvs (w_c_dvs[g+1])
        );
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_in_count   <= '0;
            r_out_count  <= '0;
            r_wcol       <= '0;
            r_wslot      <= '0;
            r_ox         <= '0;
            r_oy         <= '0;
            r_oslot      <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_cfg_hit) begin
                        r_in_count  <= '0;
                        r_out_count <= '0;
                        r_wcol      <= '0;
                        r_wslot     <= '0;
                        r_ox        <= '0;
                        r_oy        <= '0;
                        r_oslot     <= '0;
                    end else if (w_take) begin
                        if (w_pix_ok && !(w_emit && w_frame_end)) begin
                            r_in_count <= r_in_count + CW'(1);
                            if (r_wcol == XW'(r_eff_w - WW'(1))) begin
                                r_wcol  <= '0;
                                r_wslot <= (r_wslot == SW'(SLOTS - 1)) ? '0
                                                                       : r_wslot + SW'(1);
                            end else begin
                                r_wcol <= r_wcol + XW'(1);
                            end
                        end
                        if (w_emit) begin
                            r_cx         <= r_ox;
                            r_cy         <= r_oy;
                            r_cslot      <= r_oslot;
                            r_last_pend  <= (r_out_count == (r_total - CW'(1)));
                            r_dxo        <= '0;
                            r_dyo        <= '0;
                            r_issue_done <= 1'b0;
                            r_sum        <= '0;
                            r_state      <= S_SUM;
                            if (w_frame_end) begin
                                r_in_count  <= '0;
                                r_out_count <= '0;
                                r_wcol      <= '0;
                                r_wslot     <= '0;
                                r_ox        <= '0;
                                r_oy        <= '0;
                                r_oslot     <= '0;
                            end else begin
                                r_out_count <= r_out_count + CW'(1);
                                if (r_ox == XW'(r_eff_w - WW'(1))) begin
                                    r_ox    <= '0;
                                    r_oy    <= r_oy + YW'(1);
                                    r_oslot <= (r_oslot == SW'(SLOTS - 1)) ? '0
                                                                           : r_oslot + SW'(1);
                                end else begin
                                    r_ox <= r_ox + XW'(1);
                                end
                            end
                        end
                    end
                end
                S_SUM: begin
                    r_rd_vld <= !r_issue_done;
                    if (r_rd_vld) begin
                        r_sum <= r_sum + SUMW'(r_mem_q);
                    end
                    if (!r_issue_done) begin
                        if (r_dxo == OW'(2 * r_eff_r)) begin
                            r_dxo <= '0;
                            if (r_dyo == OW'(2 * r_eff_r)) begin
                                r_issue_done <= 1'b1;
                            end else begin
                                r_dyo <= r_dyo + OW'(1);
                            end
                        end else begin
                            r_dxo <= r_dxo + OW'(1);
                        end
                    end else if (!r_rd_vld) begin
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + (DCW+1)'(1);
                    if (r_div_cnt == (DCW+1)'(QB - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_pixel_out  <= w_c_quo[QB];
            r_frame_last <= r_last_pend;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pixel_out;
    assign o_frame_last = r_frame_last;

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input taken while a window is in progress");

    a_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cfg_hold |-> (r_in_count <= r_total))
        else $error("input count ran past frame size");

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cfg_hold |-> (r_out_count < r_total))
        else $error("output count ran past frame size");

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> $stable(r_sum))
        else $error("window sum moved during division");

endmodule
